// ===== hdl/doipc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// doipc_pkg: shared types, constants and helpers for the DoIP request classifier
// Holds the port word formats, the configuration image, register indexes,
// header layout constants and the EID/VIN character selectors.
// ----------------------------------------------------------------------------
package doipc_pkg;

	// Header layout and compare lengths
	localparam int unsigned HDR_LEN = 8;
	localparam int unsigned EID_LEN = 6;
	localparam int unsigned VIN_LEN = 17;
	localparam int unsigned POS_W   = 5;
	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	// Byte positions inside the generic header
	localparam logic [POS_W-1:0] POS_VERSION = 5'd0;
	localparam logic [POS_W-1:0] POS_INVERSE = 5'd1;
	localparam logic [POS_W-1:0] POS_TYPE_END = 5'd4;
	localparam logic [POS_W-1:0] POS_HDR_END  = 5'd8;

	// Last byte position that still leaves the header short
	localparam logic [POS_W-1:0] POS_SHORT_MAX = 5'd6;
	// Minimum last byte position for a complete EID or VIN payload
	localparam logic [POS_W-1:0] POS_EID_DONE = 5'd13;
	localparam logic [POS_W-1:0] POS_VIN_DONE = 5'd24;

	// Accepted protocol versions
	localparam logic [7:0] VER_2010 = 8'h01;
	localparam logic [7:0] VER_2012 = 8'h02;
	localparam logic [7:0] VER_2019 = 8'h03;
	localparam logic [7:0] VER_ANY  = 8'hFF;

	// Payload type codes
	localparam logic [15:0] PT_VEH_ID     = 16'h0001;
	localparam logic [15:0] PT_VEH_ID_EID = 16'h0002;
	localparam logic [15:0] PT_VEH_ID_VIN = 16'h0003;
	localparam logic [15:0] PT_ENT_STATUS = 16'h4001;
	localparam logic [15:0] PT_POWER_MODE = 16'h4003;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ENTITY_ID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIN_HEAD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIN_MIDDLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIN_TAIL   = 3'd3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_VEH_ID     = 3'd1,
		KIND_VEH_ID_EID = 3'd2,
		KIND_VEH_ID_VIN = 3'd3,
		KIND_ENT_STATUS = 3'd4,
		KIND_POWER_MODE = 3'd5
	} req_kind_t;

	typedef enum logic [1:0] {
		HST_OK        = 2'd0,
		HST_SHORT     = 2'd1,
		HST_BAD_PATTN = 2'd2
	} hdr_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  request_kind;
		logic [1:0]  header_status;
		logic        selects_us;
		logic [15:0] msg_type;
		logic [31:0] payload_length;
	} out_word_t;

	typedef struct packed {
		logic [47:0] entity_id;
		logic [63:0] vin_head;
		logic [63:0] vin_middle;
		logic [7:0]  vin_tail;
	} cfg_t;

	// EID character k, first character most significant
	function automatic logic [7:0] eid_char(input logic [47:0] eid, input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0:    c = eid[47:40];
			3'd1:    c = eid[39:32];
			3'd2:    c = eid[31:24];
			3'd3:    c = eid[23:16];
			3'd4:    c = eid[15:8];
			3'd5:    c = eid[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// VIN character k across the three registers
	function automatic logic [7:0] vin_char(input cfg_t cfg, input logic [POS_W-1:0] k);
		logic [7:0] c;
		case (k)
			5'd0:    c = cfg.vin_head[63:56];
			5'd1:    c = cfg.vin_head[55:48];
			5'd2:    c = cfg.vin_head[47:40];
			5'd3:    c = cfg.vin_head[39:32];
			5'd4:    c = cfg.vin_head[31:24];
			5'd5:    c = cfg.vin_head[23:16];
			5'd6:    c = cfg.vin_head[15:8];
			5'd7:    c = cfg.vin_head[7:0];
			5'd8:    c = cfg.vin_middle[63:56];
			5'd9:    c = cfg.vin_middle[55:48];
			5'd10:   c = cfg.vin_middle[47:40];
			5'd11:   c = cfg.vin_middle[39:32];
			5'd12:   c = cfg.vin_middle[31:24];
			5'd13:   c = cfg.vin_middle[23:16];
			5'd14:   c = cfg.vin_middle[15:8];
			5'd15:   c = cfg.vin_middle[7:0];
			5'd16:   c = cfg.vin_tail;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/doipc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// doipc_cfg_regs: configuration register file
// Write-only registers for the entity EID and the three VIN segments.
// Unknown indexes are dropped; bits above a register's width are dropped.
// ----------------------------------------------------------------------------
module doipc_cfg_regs (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire [doipc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [doipc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output doipc_pkg::cfg_t                      cfg
);

	doipc_pkg::cfg_t cfg_q;

	// Capture writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				doipc_pkg::REG_ENTITY_ID: begin
					cfg_q.entity_id <= cfg_wdata[47:0];
				end
				doipc_pkg::REG_VIN_HEAD: begin
					cfg_q.vin_head <= cfg_wdata;
				end
				doipc_pkg::REG_VIN_MIDDLE: begin
					cfg_q.vin_middle <= cfg_wdata;
				end
				doipc_pkg::REG_VIN_TAIL: begin
					cfg_q.vin_tail <= cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/doipc_hdr_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// doipc_hdr_parser: per-datagram header state and classification
// Updates the header state for one byte per advance and forms the result
// word combinationally from the updated state when the byte is marked last.
// ----------------------------------------------------------------------------
module doipc_hdr_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  doipc_pkg::in_word_t  word,
	input  doipc_pkg::cfg_t      cfg,
	output doipc_pkg::out_word_t res
);

	logic [doipc_pkg::POS_W-1:0] pos_q;
	logic [7:0]  ver_q;
	logic        pat_q;
	logic [15:0] type_q;
	logic [31:0] len_q;
	logic        eid_q;
	logic        vin_q;

	logic [7:0]  nxt_ver;
	logic        nxt_pat;
	logic [15:0] nxt_type;
	logic [31:0] nxt_len;
	logic        nxt_eid;
	logic        nxt_vin;
	logic [doipc_pkg::POS_W-1:0] k;
	logic        ver_ok;
	logic        sel;

	assign k = pos_q - doipc_pkg::POS_HDR_END;
	assign ver_ok = (ver_q == doipc_pkg::VER_2010) || (ver_q == doipc_pkg::VER_2012) ||
	                (ver_q == doipc_pkg::VER_2019) || (ver_q == doipc_pkg::VER_ANY);

	// Next header state for this byte
	always_comb begin
		nxt_ver  = ver_q;
		nxt_pat  = pat_q;
		nxt_type = type_q;
		nxt_len  = len_q;
		nxt_eid  = eid_q;
		nxt_vin  = vin_q;
		if (pos_q == doipc_pkg::POS_VERSION) begin
			nxt_ver = word.data_byte;
		end else if (pos_q == doipc_pkg::POS_INVERSE) begin
			nxt_pat = ver_ok && (word.data_byte == ~ver_q);
		end else if (pos_q < doipc_pkg::POS_TYPE_END) begin
			nxt_type = {type_q[7:0], word.data_byte};
		end else if (pos_q < doipc_pkg::POS_HDR_END) begin
			nxt_len = {len_q[23:0], word.data_byte};
		end else begin
			if ((k < 5'(doipc_pkg::EID_LEN)) &&
			    (word.data_byte != doipc_pkg::eid_char(cfg.entity_id, k[2:0]))) begin
				nxt_eid = 1'b0;
			end
			if ((k < 5'(doipc_pkg::VIN_LEN)) &&
			    (word.data_byte != doipc_pkg::vin_char(cfg, k))) begin
				nxt_vin = 1'b0;
			end
		end
	end

	// Classify from the updated state
	always_comb begin
		res = '0;
		case (nxt_type)
			doipc_pkg::PT_VEH_ID_EID: sel = (pos_q >= doipc_pkg::POS_EID_DONE) && nxt_eid;
			doipc_pkg::PT_VEH_ID_VIN: sel = (pos_q >= doipc_pkg::POS_VIN_DONE) && nxt_vin;
			default:                  sel = 1'b1;
		endcase
		if (pos_q <= doipc_pkg::POS_SHORT_MAX) begin
			res.header_status = doipc_pkg::HST_SHORT;
		end else begin
			res.msg_type       = nxt_type;
			res.payload_length = nxt_len;
			res.selects_us     = sel;
			if (!nxt_pat) begin
				res.header_status = doipc_pkg::HST_BAD_PATTN;
			end else begin
				res.header_status = doipc_pkg::HST_OK;
				case (nxt_type)
					doipc_pkg::PT_VEH_ID:     res.request_kind = doipc_pkg::KIND_VEH_ID;
					doipc_pkg::PT_VEH_ID_EID: res.request_kind = doipc_pkg::KIND_VEH_ID_EID;
					doipc_pkg::PT_VEH_ID_VIN: res.request_kind = doipc_pkg::KIND_VEH_ID_VIN;
					doipc_pkg::PT_ENT_STATUS: res.request_kind = doipc_pkg::KIND_ENT_STATUS;
					doipc_pkg::PT_POWER_MODE: res.request_kind = doipc_pkg::KIND_POWER_MODE;
					default:                  res.request_kind = doipc_pkg::KIND_NONE;
				endcase
			end
		end
	end

	// Advance the state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ver_q  <= '0;
			pat_q  <= 1'b0;
			type_q <= '0;
			len_q  <= '0;
			eid_q  <= 1'b1;
			vin_q  <= 1'b1;
		end else if (adv) begin
			if (word.last_byte) begin
				pos_q  <= '0;
				ver_q  <= '0;
				pat_q  <= 1'b0;
				type_q <= '0;
				len_q  <= '0;
				eid_q  <= 1'b1;
				vin_q  <= 1'b1;
			end else begin
				if (pos_q != doipc_pkg::POS_MAX) begin
					pos_q <= pos_q + 5'd1;
				end
				ver_q  <= nxt_ver;
				pat_q  <= nxt_pat;
				type_q <= nxt_type;
				len_q  <= nxt_len;
				eid_q  <= nxt_eid;
				vin_q  <= nxt_vin;
			end
		end
	end

	// Position restarts after a last byte
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && word.last_byte |=> pos_q == '0 && !pat_q && eid_q && vin_q)
		else $error("header state not cleared after last byte");

	// Position holds once saturated
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !word.last_byte && pos_q == doipc_pkg::POS_MAX |=> pos_q == doipc_pkg::POS_MAX)
		else $error("byte position wrapped past saturation");

	// A short datagram reports no type, length or selection
	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.header_status == doipc_pkg::HST_SHORT |->
		res.msg_type == '0 && res.payload_length == '0 && !res.selects_us &&
		res.request_kind == doipc_pkg::KIND_NONE)
		else $error("short datagram result carries header fields");

endmodule
`default_nettype wire

// ===== hdl/doip_udp_request_classifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// doip_udp_request_classifier_top: DoIP UDP generic header classifier
// Channel   Dir  Handshake          Word
// in        in   in_valid/in_stall  in_data  (data_byte, last_byte)
// out       out  out_valid/out_stall out_data (kind, status, select, type, length)
// cfg       in   cfg_we             cfg_index, cfg_wdata
//
// One byte word is taken per cycle while in_stall is low; a result passes through
// the input register, then the result register, after its last byte is taken.
// Per-byte work is one header-field update, or one EID and one VIN character compare.
// in_stall rises only when a last-marked word waits behind a stalled result.
// Reset clears the header state (match flags set) and zeroes all
// configuration registers.
// ----------------------------------------------------------------------------
module doip_udp_request_classifier_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  doipc_pkg::in_word_t              in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output doipc_pkg::out_word_t             out_data,
	input  wire                              cfg_we,
	input  wire [doipc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [doipc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	doipc_pkg::cfg_t      cfg;
	doipc_pkg::in_word_t  word_s1;
	logic                 valid_s1;
	doipc_pkg::out_word_t res;
	doipc_pkg::out_word_t out_q;
	logic                 out_valid_q;
	logic                 adv;
	logic                 in_take;

	doipc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	doipc_hdr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.word   (word_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Advance a word unless it needs the result register and that is blocked
	assign adv      = valid_s1 && (!word_s1.last_byte || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_data;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && word_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv && word_s1.last_byte) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Stall only when a last word meets a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && word_s1.last_byte && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// A new result only comes from a last-marked word
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && word_s1.last_byte))
		else $error("result raised without a last word");

	// A held result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(adv && word_s1.last_byte))
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// ===== tb/tb_doip_udp_request_classifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_doip_udp_request_classifier_top: self-checking bench for the DoIP classifier
// Streams datagrams into the classifier one byte word at a time. A bench-side
// model of the header parser works out the result of each datagram. Directed
// frames cover short, bad-pattern, saturated and EID/VIN cases. Random frames
// follow, with register images changed between phases and both handshakes
// idled and stalled at random.
// ----------------------------------------------------------------------------
module tb_doip_udp_request_classifier_top;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES   = 8;
	localparam int unsigned RANDOM_BYTES  = 224;
	localparam int unsigned RANDOM_FRAMES = 16;
	localparam int unsigned PHASE_FRAMES  = 6;
	localparam int unsigned DIRECTED_ROWS = 19;
	// Row before which the directed part loads non-zero identities
	localparam int unsigned CFG_ROW       = 15;
	localparam logic [doipc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [doipc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [2:0] {
		FILL_ZERO,
		FILL_ONES,
		FILL_EID,
		FILL_VIN,
		FILL_RAND
	} fill_t;

	typedef struct packed {
		logic [6:0]           nbytes;
		logic [7:0]           ver;
		logic [7:0]           inv;
		logic [15:0]          ptype;
		logic [31:0]          plen;
		fill_t                fill;
		logic                 pinned;
		doipc_pkg::out_word_t want;
	} frame_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	doipc_pkg::in_word_t  in_data;
	logic                 out_valid;
	logic                 out_stall;
	doipc_pkg::out_word_t out_data;
	logic                 cfg_we;
	logic [doipc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [doipc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Fixed result travelling with the word, used instead of the prediction
	logic                 pin_flag;
	doipc_pkg::out_word_t pin_word;

	// Register image and header parser state of the bench model
	doipc_pkg::cfg_t reg_image;
	logic [4:0]      at_byte;
	logic [7:0]      seen_version;
	logic            pattern_ok;
	logic [15:0]     type_acc;
	logic [31:0]     length_acc;
	logic            eid_ok;
	logic            vin_ok;

	doipc_pkg::out_word_t pending_results[$];
	logic [7:0]           frame_bytes[$];
	frame_row_t           directed_rows[DIRECTED_ROWS];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycles = 0;

	doip_udp_request_classifier_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [7:0] eid_octet(input int unsigned k);
		logic [47:0] s;
		s = reg_image.entity_id >> (8 * (doipc_pkg::EID_LEN - 1 - k));
		return s[7:0];
	endfunction

	function automatic logic [7:0] vin_octet(input int unsigned k);
		logic [135:0] s;
		s = {reg_image.vin_head, reg_image.vin_middle, reg_image.vin_tail} >>
			(8 * (doipc_pkg::VIN_LEN - 1 - k));
		return s[7:0];
	endfunction

	task automatic clear_frame_state();
		at_byte      = '0;
		seen_version = '0;
		pattern_ok   = 1'b0;
		type_acc     = '0;
		length_acc   = '0;
		eid_ok       = 1'b1;
		vin_ok       = 1'b1;
	endtask

	// Advance the header parser by one word; queue the result on the last one
	task automatic classify_byte(input doipc_pkg::in_word_t w, input logic pin,
		input doipc_pkg::out_word_t pinned);
		logic [4:0]           p;
		int unsigned          k;
		doipc_pkg::out_word_t res;
		p = at_byte;
		if (p == doipc_pkg::POS_VERSION) begin
			seen_version = w.data_byte;
		end else if (p == doipc_pkg::POS_INVERSE) begin
			pattern_ok = (seen_version == doipc_pkg::VER_2010 ||
				seen_version == doipc_pkg::VER_2012 ||
				seen_version == doipc_pkg::VER_2019 ||
				seen_version == doipc_pkg::VER_ANY) &&
				(w.data_byte == ~seen_version);
		end else if (p < doipc_pkg::POS_TYPE_END) begin
			type_acc = {type_acc[7:0], w.data_byte};
		end else if (p < doipc_pkg::POS_HDR_END) begin
			length_acc = {length_acc[23:0], w.data_byte};
		end else begin
			k = p - doipc_pkg::HDR_LEN;
			if (k < doipc_pkg::EID_LEN && w.data_byte != eid_octet(k))
				eid_ok = 1'b0;
			if (k < doipc_pkg::VIN_LEN && w.data_byte != vin_octet(k))
				vin_ok = 1'b0;
		end
		if (p != doipc_pkg::POS_MAX)
			at_byte = p + 1'b1;
		if (!w.last_byte)
			return;

		res = '0;
		if (p < doipc_pkg::HDR_LEN - 1) begin
			res.header_status = doipc_pkg::HST_SHORT;
		end else begin
			res.msg_type       = type_acc;
			res.payload_length = length_acc;
			if (type_acc == doipc_pkg::PT_VEH_ID_EID)
				res.selects_us = (p >= doipc_pkg::HDR_LEN - 1 + doipc_pkg::EID_LEN) &&
					eid_ok;
			else if (type_acc == doipc_pkg::PT_VEH_ID_VIN)
				res.selects_us = (p >= doipc_pkg::HDR_LEN - 1 + doipc_pkg::VIN_LEN) &&
					vin_ok;
			else
				res.selects_us = 1'b1;
			if (!pattern_ok) begin
				res.header_status = doipc_pkg::HST_BAD_PATTN;
				res.request_kind  = doipc_pkg::KIND_NONE;
			end else begin
				res.header_status = doipc_pkg::HST_OK;
				case (type_acc)
					doipc_pkg::PT_VEH_ID:     res.request_kind = doipc_pkg::KIND_VEH_ID;
					doipc_pkg::PT_VEH_ID_EID: res.request_kind = doipc_pkg::KIND_VEH_ID_EID;
					doipc_pkg::PT_VEH_ID_VIN: res.request_kind = doipc_pkg::KIND_VEH_ID_VIN;
					doipc_pkg::PT_ENT_STATUS: res.request_kind = doipc_pkg::KIND_ENT_STATUS;
					doipc_pkg::PT_POWER_MODE: res.request_kind = doipc_pkg::KIND_POWER_MODE;
					default:                  res.request_kind = doipc_pkg::KIND_NONE;
				endcase
			end
		end
		pending_results.push_back(pin ? pinned : res);
		clear_frame_state();
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare results first, then take in the accepted byte word
	always @(posedge clk) begin : result_check
		doipc_pkg::out_word_t want;
		if (!arst_n) begin
			clear_frame_state();
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing waiting: 0x%0h", out_data);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("request_kind", want.request_kind, out_data.request_kind);
					check_field("header_status", want.header_status, out_data.header_status);
					check_field("selects_us", want.selects_us, out_data.selects_us);
					check_field("msg_type", want.msg_type, out_data.msg_type);
					check_field("payload_length", want.payload_length,
						out_data.payload_length);
				end
			end
			if (in_valid && !in_stall)
				classify_byte(in_data, pin_flag, pin_word);
		end
	end

	// Stall the result side in bursts, with free stretches between
	initial begin : result_stall
		int unsigned r;
		int unsigned n;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				out_stall <= 1'b0;
				n = $urandom_range(20, 60);
			end else if (r < 60) begin
				out_stall <= 1'b1;
				n = idle_len() + 1;
			end else begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 6);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Drive one byte word and hold it until taken
	task automatic send_word(input logic [7:0] b, input logic l, input logic pin,
		input doipc_pkg::out_word_t want, input bit steady);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: l};
		pin_flag <= pin;
		pin_word <= want;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic pin, input doipc_pkg::out_word_t want);
		bit steady;
		int unsigned n;
		steady = ($urandom_range(0, 3) == 0);
		n = frame_bytes.size();
		for (int unsigned i = 0; i < n; i++)
			send_word(frame_bytes[i], i == n - 1, pin && (i == n - 1), want, steady);
	endtask

	task automatic build_frame(input int unsigned n, input logic [7:0] ver, input logic [7:0] inv,
		input logic [15:0] ptype, input logic [31:0] plen, input fill_t fill);
		logic [31:0] s;
		int unsigned k;
		frame_bytes.delete();
		for (int unsigned i = 0; i < n; i++) begin
			if (i == 0) begin
				frame_bytes.push_back(ver);
			end else if (i == 1) begin
				frame_bytes.push_back(inv);
			end else if (i < 4) begin
				frame_bytes.push_back(i == 2 ? ptype[15:8] : ptype[7:0]);
			end else if (i < doipc_pkg::HDR_LEN) begin
				s = plen >> (8 * (doipc_pkg::HDR_LEN - 1 - i));
				frame_bytes.push_back(s[7:0]);
			end else begin
				k = i - doipc_pkg::HDR_LEN;
				case (fill)
					FILL_ZERO: frame_bytes.push_back(8'h00);
					FILL_ONES: frame_bytes.push_back(8'hFF);
					FILL_EID:  frame_bytes.push_back(k < doipc_pkg::EID_LEN ?
						eid_octet(k) : 8'($urandom));
					FILL_VIN:  frame_bytes.push_back(k < doipc_pkg::VIN_LEN ?
						vin_octet(k) : 8'($urandom));
					default:   frame_bytes.push_back(8'($urandom));
				endcase
			end
		end
	endtask

	// Hold off the sender until every result is back and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [doipc_pkg::CFG_IDX_W-1:0] idx,
		input logic [doipc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Load all identity registers, plus a write to an unused index
	task automatic load_regs(input logic [63:0] eid, input logic [63:0] vh,
		input logic [63:0] vm, input logic [63:0] vt);
		write_reg(doipc_pkg::REG_ENTITY_ID, eid);
		reg_image.entity_id = eid[47:0];
		write_reg(doipc_pkg::REG_VIN_HEAD, vh);
		reg_image.vin_head = vh;
		write_reg(doipc_pkg::REG_VIN_MIDDLE, vm);
		reg_image.vin_middle = vm;
		write_reg(doipc_pkg::REG_VIN_TAIL, vt);
		reg_image.vin_tail = vt[7:0];
		write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed requests with random content, some noise
	task automatic send_random_frame();
		int unsigned r;
		int unsigned n;
		int unsigned pick;
		int unsigned cmp;
		int unsigned lim;
		logic [7:0]  ver;
		logic [15:0] ptype;
		logic [31:0] plen;
		fill_t       fill;
		r = $urandom_range(0, 99);
		if (r < 16) begin
			n = (r < 8) ? $urandom_range(1, 7) : $urandom_range(8, 40);
			build_frame(n, 8'($urandom), 8'($urandom), 16'($urandom), $urandom, FILL_RAND);
		end else begin
			case ($urandom_range(0, 3))
				0:       ver = doipc_pkg::VER_2010;
				1:       ver = doipc_pkg::VER_2012;
				2:       ver = doipc_pkg::VER_2019;
				default: ver = doipc_pkg::VER_ANY;
			endcase
			case ($urandom_range(0, 3))
				0:       plen = 32'h0;
				1:       plen = 32'hFFFF_FFFF;
				default: plen = $urandom;
			endcase
			cmp  = 0;
			fill = FILL_RAND;
			n    = doipc_pkg::HDR_LEN + $urandom_range(0, 4);
			pick = $urandom_range(0, 9);
			case (pick)
				0:       ptype = doipc_pkg::PT_VEH_ID;
				1, 8: begin
					ptype = doipc_pkg::PT_VEH_ID_EID;
					fill  = FILL_EID;
					cmp   = doipc_pkg::EID_LEN;
					n     = doipc_pkg::HDR_LEN +
						$urandom_range(doipc_pkg::EID_LEN - 2, doipc_pkg::EID_LEN + 2);
				end
				2, 9: begin
					ptype = doipc_pkg::PT_VEH_ID_VIN;
					fill  = FILL_VIN;
					cmp   = doipc_pkg::VIN_LEN;
					n     = doipc_pkg::HDR_LEN +
						$urandom_range(doipc_pkg::VIN_LEN - 3, doipc_pkg::VIN_LEN + 3);
				end
				3:       ptype = doipc_pkg::PT_ENT_STATUS;
				4:       ptype = doipc_pkg::PT_POWER_MODE;
				5:       ptype = 16'h0000;
				6:       ptype = 16'hFFFF;
				default: ptype = 16'($urandom);
			endcase
			if ($urandom_range(0, 19) == 0)
				n = $urandom_range(26, 40);
			build_frame(n, ver, ~ver, ptype, plen, fill);
			// Break the inverse byte now and then
			if ($urandom_range(0, 11) == 0)
				frame_bytes[1] ^= 8'(1 << $urandom_range(0, 7));
			// Corrupt one compared identity byte now and then
			if (cmp != 0 && n > doipc_pkg::HDR_LEN && $urandom_range(0, 6) == 0) begin
				lim = (n - doipc_pkg::HDR_LEN < cmp) ? n - doipc_pkg::HDR_LEN : cmp;
				frame_bytes[doipc_pkg::HDR_LEN + $urandom_range(0, lim - 1)] ^=
					8'($urandom_range(1, 255));
			end
		end
		send_frame(1'b0, '0);
	endtask

	initial begin : stimulus
		int unsigned frames;
		int unsigned phase;
		frame_row_t  row;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		pin_flag  <= 1'b0;
		pin_word  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= doipc_pkg::REG_ENTITY_ID;
		cfg_wdata <= '0;
		reg_image = '0;

		// Directed frames; identities are zero until the row marked for loading
		directed_rows[0]  = '{7'd1, 8'h00, 8'h00, 16'h0000, 32'h0, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_SHORT, 1'b0, 16'h0, 32'h0}};
		directed_rows[1]  = '{7'd7, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID,
			32'hFFFF_FFFF, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_SHORT, 1'b0, 16'h0, 32'h0}};
		directed_rows[2]  = '{7'd8, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID,
			32'h0, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_VEH_ID, 32'h0}};
		directed_rows[3]  = '{7'd14, doipc_pkg::VER_2012, 8'hFD, doipc_pkg::PT_VEH_ID_EID,
			32'd6, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_EID, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_VEH_ID_EID, 32'd6}};
		directed_rows[4]  = '{7'd25, doipc_pkg::VER_2019, 8'hFC, doipc_pkg::PT_VEH_ID_VIN,
			32'd17, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_VIN, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_VEH_ID_VIN, 32'd17}};
		directed_rows[5]  = '{7'd8, doipc_pkg::VER_ANY, 8'h00, doipc_pkg::PT_ENT_STATUS,
			32'hFFFF_FFFF, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_ENT_STATUS, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_ENT_STATUS, 32'hFFFF_FFFF}};
		directed_rows[6]  = '{7'd8, doipc_pkg::VER_ANY, 8'h00, doipc_pkg::PT_POWER_MODE,
			32'h8000_0001, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_POWER_MODE, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_POWER_MODE, 32'h8000_0001}};
		directed_rows[7]  = '{7'd8, 8'h00, 8'hFF, doipc_pkg::PT_VEH_ID,
			32'h0, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_BAD_PATTN, 1'b1,
			doipc_pkg::PT_VEH_ID, 32'h0}};
		directed_rows[8]  = '{7'd8, doipc_pkg::VER_2010, 8'hFF, 16'hFFFF,
			32'hFFFF_FFFF, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_BAD_PATTN, 1'b1,
			16'hFFFF, 32'hFFFF_FFFF}};
		directed_rows[9]  = '{7'd8, 8'h04, 8'hFB, doipc_pkg::PT_VEH_ID_EID,
			32'h0, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_BAD_PATTN, 1'b0,
			doipc_pkg::PT_VEH_ID_EID, 32'h0}};
		directed_rows[10] = '{7'd13, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID_EID,
			32'd5, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_EID, doipc_pkg::HST_OK, 1'b0,
			doipc_pkg::PT_VEH_ID_EID, 32'd5}};
		directed_rows[11] = '{7'd24, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID_VIN,
			32'd16, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_VIN, doipc_pkg::HST_OK, 1'b0,
			doipc_pkg::PT_VEH_ID_VIN, 32'd16}};
		directed_rows[12] = '{7'd14, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID_EID,
			32'd6, FILL_ONES, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_EID, doipc_pkg::HST_OK, 1'b0,
			doipc_pkg::PT_VEH_ID_EID, 32'd6}};
		directed_rows[13] = '{7'd40, doipc_pkg::VER_2012, 8'hFD, doipc_pkg::PT_VEH_ID_VIN,
			32'd32, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_VEH_ID_VIN, doipc_pkg::HST_OK, 1'b1,
			doipc_pkg::PT_VEH_ID_VIN, 32'd32}};
		directed_rows[14] = '{7'd8, doipc_pkg::VER_2019, 8'hFC, 16'h1234,
			32'h55AA_00FF, FILL_ZERO, 1'b1,
			'{doipc_pkg::KIND_NONE, doipc_pkg::HST_OK, 1'b1, 16'h1234, 32'h55AA_00FF}};
		directed_rows[15] = '{7'd14, doipc_pkg::VER_2010, 8'hFE, doipc_pkg::PT_VEH_ID_EID,
			32'd6, FILL_EID, 1'b0, '0};
		directed_rows[16] = '{7'd25, doipc_pkg::VER_2012, 8'hFD, doipc_pkg::PT_VEH_ID_VIN,
			32'd17, FILL_VIN, 1'b0, '0};
		directed_rows[17] = '{7'd31, doipc_pkg::VER_ANY, 8'h00, doipc_pkg::PT_VEH_ID_VIN,
			32'd23, FILL_VIN, 1'b0, '0};
		directed_rows[18] = '{7'd12, doipc_pkg::VER_2010, 8'hFE, 16'h0000,
			32'h0, FILL_RAND, 1'b0, '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == CFG_ROW) begin
				drain();
				load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
			end
			row = directed_rows[i];
			build_frame(row.nbytes, row.ver, row.inv, row.ptype, row.plen, row.fill);
			send_frame(row.pinned, row.want);
		end

		// Random frames, cycling the identities through ones, random and zeros
		bytes_sent = 0;
		frames = 0;
		phase = 0;
		while (bytes_sent < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
			if (frames % PHASE_FRAMES == 0) begin
				drain();
				case (phase % 3)
					0:       load_regs('1, '1, '1, '1);
					1:       load_regs({$urandom, $urandom}, {$urandom, $urandom},
							{$urandom, $urandom}, {$urandom, $urandom});
					default: load_regs('0, '0, '0, '0);
				endcase
				phase++;
			end
			send_random_frame();
			frames++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
